>>> hw/rtl/sorted_endpoint_binary_search_unit_defines.svh
// Assertion macros for the sorted endpoint binary search unit.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef SORTED_ENDPOINT_BINARY_SEARCH_UNIT_DEFINES_SVH
`define SORTED_ENDPOINT_BINARY_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define SEBS_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sebs assertion failed");

`define SEBS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sebs assertion failed");

`else

`define SEBS_ASSERT_SAME(name, ante, cons)

`define SEBS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> hw/rtl/sebs_pkg.sv
// Package for the sorted endpoint binary search unit.
// Holds operation codes, field widths and the sequencer state type; no dependencies.
package sebs_pkg;

    localparam int KEY_W = 48;
    localparam int OP_W  = 2;

    typedef logic [OP_W-1:0]  sebs_op_t;
    typedef logic [KEY_W-1:0] sebs_key_t;

    localparam sebs_op_t OP_LOAD   = 2'd0;
    localparam sebs_op_t OP_LOOKUP = 2'd1;
    localparam sebs_op_t OP_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_OUT
    } sebs_state_t;

endpackage

>>> hw/rtl/sebs_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module sebs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/sorted_endpoint_binary_search_unit.sv
// Top level of the sorted endpoint binary search unit.
// Depends on sebs_pkg, sebs_ram and sorted_endpoint_binary_search_unit_defines.svh.
//
// The slave channel takes one operation per transfer: s_tuser carries the operation
// (load pair, lookup endpoint, clear table) and s_tdata the endpoint and startpoint.
// Loads append pairs; the user must load them in ascending endpoint order, which
// the block does not enforce; clear empties the table. Every operation yields
// exactly one transfer on the master channel: m_tdata holds the startpoint of a
// matched entry, m_tuser the found and table-full flags. A lookup is a lower-bound
// search with one probe of the endpoint memory per cycle, and the number of probes
// is at most ceil(log2(entries + 1)). The single read port of the endpoint memory
// sets that probe rate. Load, clear and unused codes go straight from idle to the
// output state. One operation is in flight at a time; s_tready is high only when
// the sequencer is idle, and a result may still wait in the output register.
// If the receiver stalls, the next result waits until the output register is free.
// Reset empties the table and the output register; memory contents are not cleared,
// as only entries below the entry count are ever used.

`include "sorted_endpoint_binary_search_unit_defines.svh"

module sorted_endpoint_binary_search_unit #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [2*sebs_pkg::KEY_W-1:0] s_tdata,  // end_key [47:0], start_in [95:48]
    input  sebs_pkg::sebs_op_t         s_tuser,    // op [1:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output sebs_pkg::sebs_key_t        m_tdata,    // start_out [47:0]
    output logic [1:0]                 m_tuser     // found [0], table_full [1]
);

    import sebs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    sebs_state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    sebs_key_t     key_reg, key_next;
    logic          res_found_reg, res_found_next;
    sebs_key_t     res_start_reg, res_start_next;
    logic          res_full_reg, res_full_next;
    logic          m_tvalid_reg, m_tvalid_next;
    sebs_key_t     m_tdata_reg, m_tdata_next;
    logic [1:0]    m_tuser_reg, m_tuser_next;

    logic          in_xfer;
    logic          out_free;
    logic          table_has_room;
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    sebs_key_t     rd_end;
    sebs_key_t     rd_start;
    sebs_key_t     in_end;
    sebs_key_t     in_start;

    logic          go_right;
    logic          probe_more;
    logic [CW-1:0] mid_plus1;
    logic [SW-1:0] sum_right;
    logic [SW-1:0] sum_left;
    logic [CW-1:0] mid_right;
    logic [CW-1:0] mid_left;

    assign in_end         = s_tdata[KEY_W-1:0];
    assign in_start       = s_tdata[2*KEY_W-1:KEY_W];
    assign s_tready       = (state_reg == ST_IDLE);
    assign in_xfer        = s_tvalid && s_tready;
    assign out_free       = !m_tvalid_reg || m_tready;
    assign table_has_room = (count_reg < DEPTH_C);
    assign ram_we         = in_xfer && (s_tuser == OP_LOAD) && table_has_room;

    assign go_right  = (rd_end < key_reg);
    assign mid_plus1 = mid_reg + CW'(1);
    assign sum_right = {1'b0, mid_plus1} + {1'b0, hi_reg};
    assign sum_left  = {1'b0, lo_reg} + {1'b0, mid_reg};
    assign mid_right = sum_right[SW-1:1];
    assign mid_left  = sum_left[SW-1:1];
    assign probe_more = go_right ? (mid_plus1 < hi_reg) : (lo_reg < mid_reg);

    sebs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_end_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_end),
        .rd_addr (ram_raddr),
        .rd_data (rd_end)
    );

    sebs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_start_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_start),
        .rd_addr (ram_raddr),
        .rd_data (rd_start)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == OP_LOOKUP) begin
                        state_next = (count_reg == '0) ? ST_CHECK : ST_PROBE;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_PROBE: begin
                state_next = probe_more ? ST_PROBE : ST_CHECK;
            end
            ST_CHECK: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        res_found_next = res_found_reg;
        res_start_next = res_start_reg;
        res_full_next  = res_full_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        ram_raddr      = mid_reg[AW-1:0];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                ram_raddr = AW'(count_reg >> 1);
                if (in_xfer) begin
                    key_next       = in_end;
                    lo_next        = '0;
                    hi_next        = count_reg;
                    mid_next       = count_reg >> 1;
                    res_found_next = 1'b0;
                    res_start_next = '0;
                    res_full_next  = (s_tuser == OP_LOAD) && !table_has_room;
                    if (ram_we) begin
                        count_next = count_reg + CW'(1);
                    end
                    if (s_tuser == OP_CLEAR) begin
                        count_next = '0;
                    end
                end
            end
            ST_PROBE: begin
                if (go_right) begin
                    lo_next  = mid_plus1;
                    mid_next = mid_right;
                end else begin
                    hi_next  = mid_reg;
                    mid_next = mid_left;
                end
                ram_raddr = probe_more ? mid_next[AW-1:0] : lo_next[AW-1:0];
            end
            ST_CHECK: begin
                res_found_next = (lo_reg < count_reg) && (rd_end == key_reg);
                res_start_next = res_found_next ? rd_start : '0;
                res_full_next  = 1'b0;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_start_reg;
                    m_tuser_next  = {res_full_reg, res_found_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        res_found_reg <= res_found_next;
        res_start_reg <= res_start_next;
        res_full_reg  <= res_full_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `SEBS_ASSERT_NEXT(a_full_load_dropped,
        in_xfer && (s_tuser == OP_LOAD) && (count_reg == DEPTH_C),
        count_reg == $past(count_reg))
    `SEBS_ASSERT_SAME(a_probe_window,
        state_reg == ST_PROBE,
        (lo_reg < hi_reg) && (hi_reg <= count_reg) && (mid_reg < hi_reg))
    `SEBS_ASSERT_NEXT(a_result_loaded,
        (state_reg == ST_OUT) && out_free,
        m_tvalid && (state_reg == ST_IDLE))
    `SEBS_ASSERT_NEXT(a_lookup_busy,
        in_xfer && (s_tuser == OP_LOOKUP),
        !s_tready)

endmodule

>>> test/sorted_endpoint_binary_search_unit_test.sv
// Self-checking testbench for the sorted endpoint binary search unit: loads, lookups
// and clears are predicted by a behavioural table model and compared on every result.
// Depends on sebs_pkg and the sorted_endpoint_binary_search_unit RTL.
module sorted_endpoint_binary_search_unit_test;
    import sebs_pkg::*;

    localparam int       TABLE_DEPTH = 4096;
    localparam int       STALL_LIMIT = 5000;
    localparam int       PHASE_ITEMS = 500;
    localparam int       DRAIN_CYCLES = 24;
    localparam sebs_op_t OP_SPARE    = 2'd3;

    typedef struct {
        sebs_op_t  op;
        sebs_key_t end_key;
        sebs_key_t start_in;
    } search_req_t;

    typedef struct {
        logic      found;
        sebs_key_t start_out;
        logic      table_full;
    } search_answer_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [2*KEY_W-1:0]    s_tdata = '0;
    sebs_op_t              s_tuser = OP_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    sebs_key_t             m_tdata;
    logic [1:0]            m_tuser;

    search_req_t           req_queue[$];
    search_answer_t        answer_queue[$];
    sebs_key_t             endpoints[TABLE_DEPTH];
    sebs_key_t             startpoints[TABLE_DEPTH];
    int unsigned           entry_total = 0;
    int unsigned           send_idle_pct = 0;
    int unsigned           recv_stall_pct = 0;
    int unsigned           issued = 0;
    int unsigned           errors = 0;
    int unsigned           quiet_cycles = 0;

    sorted_endpoint_binary_search_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic sebs_key_t rand_key();
        return sebs_key_t'({$urandom(), $urandom()});
    endfunction

    function automatic int unsigned first_not_below(sebs_key_t key);
        int unsigned lo = 0;
        int unsigned hi = entry_total;
        int unsigned mid;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (endpoints[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic search_answer_t predict_answer(sebs_op_t op, sebs_key_t key,
                                                      sebs_key_t start);
        search_answer_t ans = '{found: 1'b0, start_out: '0, table_full: 1'b0};
        int unsigned    pos;
        case (op)
            OP_LOAD: begin
                if (entry_total >= TABLE_DEPTH) begin
                    ans.table_full = 1'b1;
                end else begin
                    endpoints[entry_total]   = key;
                    startpoints[entry_total] = start;
                    entry_total++;
                end
            end
            OP_LOOKUP: begin
                pos = first_not_below(key);
                if (pos < entry_total && endpoints[pos] == key) begin
                    ans.found     = 1'b1;
                    ans.start_out = startpoints[pos];
                end
            end
            OP_CLEAR: begin
                entry_total = 0;
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic push_req(sebs_op_t op, sebs_key_t key, sebs_key_t start);
        search_req_t req;
        req = '{op: op, end_key: key, start_in: start};
        req_queue.insert(req_queue.size(), req);
        issued++;
    endtask

    // A well-formed batch: clear, sorted loads, then mostly lookups with some noise.
    task automatic add_batch();
        sebs_key_t   keys[$];
        int unsigned n;
        int unsigned lookups;
        int unsigned pick;
        sebs_key_t   probe;
        n = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
            keys.insert(keys.size(), rand_key());
        end
        if ($urandom_range(2) == 0) begin
            for (int d = 0; d <= n / 4; d++) begin
                keys[$urandom_range(n - 1)] = keys[$urandom_range(n - 1)];
            end
        end
        keys.sort();
        push_req(OP_CLEAR, rand_key(), rand_key());
        foreach (keys[i]) begin
            push_req(OP_LOAD, keys[i], rand_key());
        end
        lookups = $urandom_range(n, 2 * n + 4);
        for (int i = 0; i < lookups; i++) begin
            pick  = $urandom_range(99);
            probe = keys[$urandom_range(n - 1)];
            if (pick < 68) begin
                push_req(OP_LOOKUP, probe, rand_key());
            end else if (pick < 78) begin
                push_req(OP_LOOKUP, probe + 1'b1, rand_key());
            end else if (pick < 84) begin
                push_req(OP_LOOKUP, probe - 1'b1, rand_key());
            end else if (pick < 91) begin
                push_req(OP_LOOKUP, rand_key(), rand_key());
            end else if (pick < 94) begin
                push_req(OP_SPARE, rand_key(), rand_key());
            end else if (pick < 98) begin
                push_req(OP_LOAD, rand_key(), rand_key());
            end else begin
                push_req(OP_CLEAR, rand_key(), rand_key());
            end
        end
    endtask

    task automatic wait_idle();
        while (req_queue.size() != 0 || s_tvalid || answer_queue.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        search_req_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                answer_queue.insert(answer_queue.size(),
                                    predict_answer(s_tuser, s_tdata[KEY_W-1:0],
                                                   s_tdata[2*KEY_W-1:KEY_W]));
            end
            if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req = req_queue[0];
                req_queue.delete(0);
                s_tuser  <= req.op;
                s_tdata  <= {req.start_in, req.end_key};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        search_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (answer_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result found=%0b start_out=%h table_full=%0b",
                         $time, m_tuser[0], m_tdata, m_tuser[1]);
            end else begin
                want = answer_queue[0];
                answer_queue.delete(0);
                if (m_tuser[0] !== want.found) begin
                    errors++;
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, m_tuser[0]);
                end
                if (m_tdata !== want.start_out) begin
                    errors++;
                    $display("%0t: start_out expected %h actual %h",
                             $time, want.start_out, m_tdata);
                end
                if (m_tuser[1] !== want.table_full) begin
                    errors++;
                    $display("%0t: table_full expected %0b actual %0b",
                             $time, want.table_full, m_tuser[1]);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        push_req(OP_LOOKUP, '0, '1);
        push_req(OP_SPARE, '1, '1);
        push_req(OP_CLEAR, '1, '1);
        push_req(OP_LOAD, 48'h0000_0000_0001, 48'h4142_4344_4546);
        push_req(OP_LOOKUP, 48'h0000_0000_0001, '0);
        push_req(OP_LOOKUP, '0, '0);
        push_req(OP_LOOKUP, '1, '0);
        push_req(OP_CLEAR, '0, '0);
        push_req(OP_LOAD, '0, '1);
        push_req(OP_LOAD, 48'h4141_4141_4141, 48'h0000_0000_0011);
        push_req(OP_LOAD, 48'h4141_4141_4141, 48'h0000_0000_0022);
        push_req(OP_LOAD, 48'h7a7a_7a7a_7a7a, 48'haaaa_aaaa_aaaa);
        push_req(OP_LOAD, '1, '0);
        push_req(OP_LOOKUP, '0, '0);
        push_req(OP_LOOKUP, '1, '1);
        push_req(OP_LOOKUP, 48'h4141_4141_4141, '0);
        push_req(OP_LOOKUP, 48'h4141_4141_4142, '0);
        push_req(OP_LOOKUP, 48'hffff_ffff_fffe, '0);
        push_req(OP_LOAD, 48'h3030_3030_3030, 48'h5555_5555_5555);
        push_req(OP_LOOKUP, 48'h3030_3030_3030, '0);
        push_req(OP_LOOKUP, 48'h7a7a_7a7a_7a7a, '0);
        push_req(OP_SPARE, '0, '0);
        push_req(OP_CLEAR, '0, '0);
        push_req(OP_LOOKUP, '0, '0);
        while (issued < PHASE_ITEMS) begin
            add_batch();
        end
        wait_idle();

        send_idle_pct  = 51;
        recv_stall_pct = 0;
        while (issued < 2 * PHASE_ITEMS) begin
            add_batch();
        end
        wait_idle();

        send_idle_pct  = 0;
        recv_stall_pct = 51;
        while (issued < 3 * PHASE_ITEMS) begin
            add_batch();
        end
        wait_idle();

        send_idle_pct  = 12;
        recv_stall_pct = 12;
        while (issued < 4 * PHASE_ITEMS) begin
            add_batch();
        end
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0 && answer_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
